// File: hw/rtl/hss_pkg.sv
// Package for the height map shadow shader: widths, codes, FSM and
// controller/datapath link types. No dependencies.
`timescale 1ns / 1ps
package hss_pkg;
	localparam int HEIGHT_BITS = 16;
	localparam int HFRAC       = 8;
	localparam int SHADOW_BITS = HEIGHT_BITS + 8;
	localparam int SHADE_BITS  = 16;
	localparam int CFG_BITS    = 16;
	localparam int CFG_IDX_BITS = 2;
	localparam int ROOT_BITS   = 16;
	localparam logic [ROOT_BITS-1:0] ROOT_LIMIT = 16'd46341;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_LIGHT_X     = 2'd0,
		CFG_LIGHT_Y     = 2'd1,
		CFG_SHADOW_DROP = 2'd2,
		CFG_NONE        = 2'd3
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_MUL1, ST_MUL2, ST_ITER, ST_DONE
	} state_t;

	typedef struct packed {
		logic       accept;
		logic       do_mul1;
		logic       do_mul2;
		logic       do_iter;
		logic [3:0] bit_idx;
		logic       load_out;
	} cmd_t;

	typedef struct packed {
		logic dark;
	} sts_t;
endpackage

// File: hw/rtl/hss_in_if.sv
// Input channel: height sample pair and row start flag.
// Depends on hss_pkg.
`timescale 1ns / 1ps
interface hss_in_if;
	import hss_pkg::*;
	logic valid;
	logic ready;
	logic signed [HEIGHT_BITS-1:0] height_here;
	logic signed [HEIGHT_BITS-1:0] height_next;
	logic row_start;
	modport source (output valid, height_here, height_next, row_start, input ready);
	modport sink (input valid, height_here, height_next, row_start, output ready);
endinterface

// File: hw/rtl/hss_out_if.sv
// Output channel: shade and lit flag.
// Depends on hss_pkg.
`timescale 1ns / 1ps
interface hss_out_if;
	import hss_pkg::*;
	logic valid;
	logic ready;
	logic signed [SHADE_BITS-1:0] shade;
	logic lit;
	modport source (output valid, shade, lit, input ready);
	modport sink (input valid, shade, lit, output ready);
endinterface

// File: hw/rtl/hss_cfg_if.sv
// Configuration write channel: register index and data.
// Depends on hss_pkg.
`timescale 1ns / 1ps
interface hss_cfg_if;
	import hss_pkg::*;
	logic valid;
	logic ready;
	logic [CFG_IDX_BITS-1:0] index;
	logic [CFG_BITS-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// File: hw/rtl/heightmap_shadow_shader.sv
// Top level of the height map shadow shader: controller plus datapath.
// Depends on hss_pkg, the three channel interfaces, hss_ctrl and hss_dp.
`timescale 1ns / 1ps
// One pixel per input transaction, one result transaction per pixel, in order.
// Dark items (shadowed or slope not positive) get the slope multiply, then the
// output load; lit ones add squaring and a 16-step bit-serial root divider
// before the load, finding floor(|N|/sqrt(d^2+1)) one bit a cycle.
// The input is taken only when the previous item has left the datapath;
// the finished result sits in an output register so a stalled sink does not
// stop the next item's work. Shadow level updates at accept, reset by
// row_start. Config writes are always ready; write only while idle.
module heightmap_shadow_shader (
	input logic clk,
	input logic arst_n,
	hss_in_if.sink    in_ch,
	hss_out_if.source out_ch,
	hss_cfg_if.sink   cfg_ch
);
	import hss_pkg::*;

	cmd_t cmd;
	sts_t sts;

	assign cfg_ch.ready = 1'b1;

	hss_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	hss_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.cfg_we      (cfg_ch.valid),
		.cfg_index   (cfg_ch.index),
		.cfg_data    (cfg_ch.data),
		.height_here (in_ch.height_here),
		.height_next (in_ch.height_next),
		.row_start   (in_ch.row_start),
		.shade       (out_ch.shade),
		.lit         (out_ch.lit)
	);
endmodule

// File: hw/rtl/hss_ctrl.sv
// Controller FSM for the shadow shader: sequences multiply and root steps.
// Depends on hss_pkg.
`timescale 1ns / 1ps
module hss_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	output hss_pkg::cmd_t cmd,
	input  hss_pkg::sts_t sts
);
	import hss_pkg::*;

	state_t     state_q, state_d;
	logic [3:0] bit_q;
	logic       out_valid_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in_valid) state_d = ST_MUL1;
			ST_MUL1: state_d = sts.dark ? ST_DONE : ST_MUL2;
			ST_MUL2: state_d = ST_ITER;
			ST_ITER: if (bit_q == 4'd0) state_d = ST_DONE;
			ST_DONE: if (!out_valid_q || out_ready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.bit_idx = bit_q;
		unique case (state_q)
			ST_IDLE: cmd.accept = in_valid;
			ST_MUL1: cmd.do_mul1 = 1'b1;
			ST_MUL2: cmd.do_mul2 = 1'b1;
			ST_ITER: cmd.do_iter = 1'b1;
			ST_DONE: cmd.load_out = !out_valid_q || out_ready;
			default: cmd = '0;
		endcase
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			bit_q       <= 4'd15;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_ITER) bit_q <= bit_q - 4'd1;
			else bit_q <= 4'd15;
			if (cmd.load_out) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid_q || out_ready)) else $error("result overwritten");
	a_iter_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ITER && bit_q == 4'd0) |=> state_q == ST_DONE)
		else $error("root loop overran");
	a_accept: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |=> state_q == ST_MUL1) else $error("accept lost");
endmodule

// File: hw/rtl/hss_dp.sv
// Datapath for the shadow shader: config registers, shadow level,
// multipliers and bit-serial root divider. Depends on hss_pkg.
`timescale 1ns / 1ps
module hss_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  hss_pkg::cmd_t                       cmd,
	output hss_pkg::sts_t                       sts,
	input  logic                                cfg_we,
	input  logic [hss_pkg::CFG_IDX_BITS-1:0]    cfg_index,
	input  logic [hss_pkg::CFG_BITS-1:0]        cfg_data,
	input  logic signed [hss_pkg::HEIGHT_BITS-1:0] height_here,
	input  logic signed [hss_pkg::HEIGHT_BITS-1:0] height_next,
	input  logic                                row_start,
	output logic signed [hss_pkg::SHADE_BITS-1:0]  shade,
	output logic                                lit
);
	import hss_pkg::*;

	localparam logic signed [SHADOW_BITS-1:0] LVL_MIN = {1'b1, {(SHADOW_BITS-1){1'b0}}};
	localparam logic signed [SHADOW_BITS-1:0] LVL_MAX = {1'b0, {(SHADOW_BITS-1){1'b1}}};

	logic signed [15:0] lx_q, ly_q, drop_q;
	logic signed [SHADOW_BITS-1:0] level_q;
	logic [15:0] d_q;
	logic        dark_q;
	logic        neg_q;
	logic [31:0] a_q, s_q;
	logic [63:0] n2_q, p_q;
	logic [47:0] qs_q;
	logic [ROOT_BITS-1:0] q_q;
	logic signed [SHADE_BITS-1:0] shade_q;
	logic        lit_q;

	// shadow level and slope at accept
	logic signed [SHADOW_BITS-1:0] nxt_ext, lvl0, lvl1;
	logic signed [SHADOW_BITS:0]   lvl_diff;
	logic signed [HEIGHT_BITS:0]   d_full;
	logic        dark_now;
	always_comb begin
		nxt_ext  = SHADOW_BITS'(height_next);
		lvl0     = row_start ? LVL_MIN : level_q;
		lvl1     = (nxt_ext > lvl0) ? nxt_ext : lvl0;
		d_full   = (HEIGHT_BITS+1)'(height_next) - (HEIGHT_BITS+1)'(height_here);
		dark_now = (nxt_ext < lvl1) || (d_full <= 0);
		lvl_diff = (SHADOW_BITS+1)'(lvl1) - (SHADOW_BITS+1)'(drop_q);
	end

	// numerator and slope square
	logic signed [32:0] dl;
	logic signed [33:0] n;
	logic [33:0] n_abs;
	always_comb begin
		dl    = $signed({1'b0, d_q}) * lx_q;
		n     = (34'(ly_q) <<< HFRAC) - 34'(dl);
		n_abs = n[33] ? -n : n;
	end

	// one root bit per cycle: P = q^2*s, QS = q*s
	logic [ROOT_BITS-1:0] cand;
	logic [64:0] trial;
	logic        take;
	always_comb begin
		cand  = q_q | (ROOT_BITS'(1) << cmd.bit_idx);
		trial = {1'b0, p_q} + ({17'b0, qs_q} << (5'(cmd.bit_idx) + 5'd1))
			+ ({33'b0, s_q} << {cmd.bit_idx, 1'b0});
		take  = (cand <= ROOT_LIMIT) && (trial <= {1'b0, n2_q});
	end

	logic signed [SHADE_BITS-1:0] res;
	always_comb begin
		if (neg_q) res = (q_q > 16'd32768) ? -16'sd32768 : -$signed(q_q);
		else res = (q_q > 16'd32767) ? 16'sd32767 : $signed(q_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lx_q    <= 16'sd16384;
			ly_q    <= '0;
			drop_q  <= '0;
			level_q <= LVL_MIN;
		end else begin
			if (cfg_we) begin
				unique case (cfg_idx_t'(cfg_index))
					CFG_LIGHT_X:     lx_q   <= $signed(cfg_data);
					CFG_LIGHT_Y:     ly_q   <= $signed(cfg_data);
					CFG_SHADOW_DROP: drop_q <= $signed(cfg_data);
					default: ;
				endcase
			end
			if (cmd.accept) begin
				if (lvl_diff < (SHADOW_BITS+1)'(LVL_MIN)) level_q <= LVL_MIN;
				else if (lvl_diff > (SHADOW_BITS+1)'(LVL_MAX)) level_q <= LVL_MAX;
				else level_q <= lvl_diff[SHADOW_BITS-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			d_q    <= d_full[15:0];
			dark_q <= dark_now;
		end
		if (cmd.do_mul1) begin
			neg_q <= n[33];
			a_q   <= n_abs[31:0];
			s_q   <= 32'({16'b0, d_q} * {16'b0, d_q}) + 32'd65536;
		end
		if (cmd.do_mul2) begin
			n2_q <= {32'b0, a_q} * {32'b0, a_q};
			p_q  <= '0;
			qs_q <= '0;
			q_q  <= '0;
		end
		if (cmd.do_iter && take) begin
			q_q  <= cand;
			p_q  <= trial[63:0];
			qs_q <= qs_q + ({16'b0, s_q} << cmd.bit_idx);
		end
		if (cmd.load_out) begin
			shade_q <= dark_q ? '0 : res;
			lit_q   <= !dark_q;
		end
	end

	assign sts.dark = dark_q;
	assign shade    = shade_q;
	assign lit      = lit_q;
endmodule

// File: test/hss_checker.sv
// Result checker for the height map shadow shader: keeps its own shadow level and
// light registers, predicts shade/lit for each accepted pixel and compares in order.
// Depends on hss_pkg and the three channel interfaces.
`timescale 1ns / 1ps
module hss_checker (
	input logic clk,
	input logic arst_n,
	hss_in_if in_ch,
	hss_out_if out_ch,
	hss_cfg_if cfg_ch,
	output int fail_count,
	output int pending
);
	import hss_pkg::*;

	typedef struct {
		logic signed [SHADE_BITS-1:0] shade;
		logic lit;
	} pixel_t;

	localparam longint LEVEL_MIN = -(64'sd1 <<< (SHADOW_BITS - 1));
	localparam longint LEVEL_MAX = (64'sd1 <<< (SHADOW_BITS - 1)) - 1;

	longint lx, ly, drop, level;
	pixel_t shade_q[$];

	// sign(N) * floor(|N| / sqrt(d^2 + 1)), exact, saturated to 16 bits
	function automatic longint slope_shade(longint d);
		longint n, a, q, c, r;
		longint unsigned n2, s;
		n = -d * lx + ly * 256;
		a = (n < 0) ? -n : n;
		n2 = a * a;
		s = d * d + 65536;
		q = 0;
		for (int b = 15; b >= 0; b--) begin
			c = q | (64'd1 << b);
			if (c > ROOT_LIMIT)
				continue;
			if (longint'(c * c) * s <= n2)
				q = c;
		end
		r = (n < 0) ? -q : q;
		if (r > 32767)
			r = 32767;
		if (r < -32768)
			r = -32768;
		return r;
	endfunction

	function automatic pixel_t shade_pixel(logic signed [HEIGHT_BITS-1:0] here,
			logic signed [HEIGHT_BITS-1:0] nxt, logic row);
		pixel_t p;
		longint h, x, d;
		h = here;
		x = nxt;
		p.shade = '0;
		p.lit = 1'b0;
		if (row)
			level = LEVEL_MIN;
		if (x > level)
			level = x;
		d = x - h;
		if (!(x < level || d <= 0)) begin
			p.shade = SHADE_BITS'(slope_shade(d));
			p.lit = 1'b1;
		end
		level = level - drop;
		if (level < LEVEL_MIN)
			level = LEVEL_MIN;
		if (level > LEVEL_MAX)
			level = LEVEL_MAX;
		return p;
	endfunction

	assign pending = shade_q.size();

	always @(posedge clk or negedge arst_n) begin
		pixel_t want;
		if (!arst_n) begin
			lx = 16384;
			ly = 0;
			drop = 0;
			level = LEVEL_MIN;
			shade_q.delete();
			fail_count = 0;
		end else begin
			if (cfg_ch.valid && cfg_ch.ready) begin
				case (cfg_idx_t'(cfg_ch.index))
					CFG_LIGHT_X: begin
						lx = $signed(cfg_ch.data);
					end
					CFG_LIGHT_Y: begin
						ly = $signed(cfg_ch.data);
					end
					CFG_SHADOW_DROP: begin
						drop = $signed(cfg_ch.data);
					end
					default: ;
				endcase
			end
			if (in_ch.valid && in_ch.ready)
				shade_q.push_back(shade_pixel(in_ch.height_here, in_ch.height_next,
						in_ch.row_start));
			if (out_ch.valid && out_ch.ready) begin
				if (shade_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result shade=%0d lit=%0b",
								out_ch.shade, out_ch.lit);
				end else begin
					want = shade_q.pop_front();
					if (want.shade !== out_ch.shade || want.lit !== out_ch.lit) begin
						fail_count++;
						if (fail_count <= 10)
							$display("mismatch: shade exp %0d got %0d, lit exp %0b got %0b",
									want.shade, out_ch.shade, want.lit, out_ch.lit);
					end
				end
			end
		end
	end
endmodule

// File: test/heightmap_shadow_shader_tb.sv
// Top of the shadow shader testbench: clock, reset, register writes, pixel stimulus
// with random idling on both sides, and the verdict. Depends on hss_pkg, the
// channel interfaces, hss_checker and heightmap_shadow_shader.
`timescale 1ns / 1ps
module heightmap_shadow_shader_tb;
	import hss_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int fail_count, pending;
	int calm;	// while set, neither side idles

	hss_in_if in_ch();
	hss_out_if out_ch();
	hss_cfg_if cfg_ch();

	heightmap_shadow_shader dut (.clk(clk), .arst_n(arst_n), .in_ch(in_ch),
			.out_ch(out_ch), .cfg_ch(cfg_ch));
	hss_checker chk (.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
			.cfg_ch(cfg_ch), .fail_count(fail_count), .pending(pending));

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// the worst case, stalls included, is far below this timeout
	initial begin
		#5ms;
		$display("Verification failed");
		$finish;
	end

	// sink side: ready drops at random, about 9 percent of the time
	always @(negedge clk)
		out_ch.ready <= (calm != 0) || ($urandom_range(99) >= 9);

	// one register write; the channel then rests with valid low
	task automatic write_reg(cfg_idx_t idx, logic [CFG_BITS-1:0] val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= val;
		do @(posedge clk); while (!cfg_ch.ready);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
		@(negedge clk);
	endtask

	// one pixel transaction; idles first at random unless calm.
	// valid is left high so pixels can follow back to back
	task automatic send_pixel(logic [15:0] here, logic [15:0] nxt, logic row);
		if (calm == 0 && $urandom_range(99) < 9) begin
			in_ch.valid <= 1'b0;
			do @(negedge clk); while ($urandom_range(99) < 9);
		end
		in_ch.valid <= 1'b1;
		in_ch.height_here <= here;
		in_ch.height_next <= nxt;
		in_ch.row_start <= row;
		do @(posedge clk); while (!in_ch.ready);
		@(negedge clk);
	endtask

	// waits until every result is back, then lets the channels rest
	task automatic drain();
		in_ch.valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (30) @(negedge clk);
	endtask

	// a row: first pixel with row_start, mostly gentle random slopes so shadows form
	task automatic send_row(int len);
		logic [15:0] h, n;
		h = 16'($urandom_range(0, 8191));
		for (int i = 0; i < len; i++) begin
			case ($urandom_range(9))
				0: n = 16'($urandom);
				1, 2: n = h - 16'($urandom_range(0, 1024));
				default: n = h + 16'($urandom_range(0, 1024)) - 16'd256;
			endcase
			send_pixel(h, n, i == 0 || $urandom_range(49) == 0);
			h = n;
		end
	endtask

	initial begin
		logic [15:0] lxs[5];
		logic [15:0] lys[5];
		logic [15:0] drops[5];
		int sent;
		int len;
		lxs = '{16'h4000, 16'hC000, 16'h2D41, 16'h7FFF, 16'h0000};
		lys = '{16'h0000, 16'h4000, 16'h2D41, 16'h8000, 16'hC000};
		drops = '{16'h0000, 16'h0040, 16'h8000, 16'h7FFF, 16'hFF00};
		calm = 0;
		in_ch.valid = 1'b0;
		in_ch.height_here = '0;
		in_ch.height_next = '0;
		in_ch.row_start = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = CFG_NONE;
		cfg_ch.data = '0;
		out_ch.ready = 1'b1;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: reset light, extremes of the heights, row start, flat and falling
		send_pixel(16'h0000, 16'h0100, 1'b1);
		send_pixel(16'h8000, 16'h7FFF, 1'b0);	// largest slope
		send_pixel(16'h7FFF, 16'h8000, 1'b0);	// steepest fall: dark
		send_pixel(16'h1234, 16'h1234, 1'b0);	// flat: dark
		send_pixel(16'h0000, 16'h0001, 1'b0);	// below the raised level: shadowed
		send_pixel(16'h0000, 16'h0001, 1'b1);	// row start clears the shadow
		send_pixel(16'hFFFF, 16'h0000, 1'b0);
		drain();
		write_reg(CFG_LIGHT_X, 16'hC000);	// light from behind: lit, positive shade
		write_reg(CFG_LIGHT_Y, 16'h4000);
		write_reg(CFG_SHADOW_DROP, 16'h8000);	// negative drop: the level climbs
		send_pixel(16'h0000, 16'h0200, 1'b1);
		send_pixel(16'h8000, 16'h7FFF, 1'b0);
		send_pixel(16'h0000, 16'h0100, 1'b0);
		drain();
		write_reg(CFG_LIGHT_X, 16'h7FFF);	// out of unit range: shade saturates
		write_reg(CFG_LIGHT_Y, 16'h8000);
		write_reg(CFG_SHADOW_DROP, 16'h7FFF);	// the level sinks after each pixel
		send_pixel(16'h8000, 16'h7FFF, 1'b1);
		send_pixel(16'h0000, 16'h0001, 1'b0);
		send_pixel(16'h7F00, 16'h7FFF, 1'b0);
		send_pixel(16'hFFFF, 16'h0000, 1'b0);
		drain();

		// random phases, a fresh setting each time
		sent = 0;
		for (int ph = 0; sent < 600; ph++) begin
			if (ph < 5) begin
				write_reg(CFG_LIGHT_X, lxs[ph]);
				write_reg(CFG_LIGHT_Y, lys[ph]);
				write_reg(CFG_SHADOW_DROP, drops[ph]);
			end else begin
				write_reg(CFG_LIGHT_X, 16'($urandom));
				write_reg(CFG_LIGHT_Y, 16'($urandom));
				write_reg(CFG_SHADOW_DROP, ($urandom_range(3) == 0) ? 16'($urandom)
						: 16'($urandom_range(0, 512)));
			end
			calm = (ph == 2);	// one phase with no idling on either side
			for (int r = 0; r < 4; r++) begin
				len = $urandom_range(4, 20);
				send_row(len);
				sent += len;
				if (r == 1) begin	// hold off until every result is back
					in_ch.valid <= 1'b0;
					do @(negedge clk); while (pending != 0);
				end
			end
			// noise: any heights at all
			for (int k = 0; k < 5; k++) begin
				send_pixel(16'($urandom), 16'($urandom), 1'($urandom));
				sent++;
			end
			calm = 0;
			drain();
		end

		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule

// File: files.f
hw/rtl/hss_pkg.sv
hw/rtl/hss_in_if.sv
hw/rtl/hss_out_if.sv
hw/rtl/hss_cfg_if.sv
hw/rtl/hss_ctrl.sv
hw/rtl/hss_dp.sv
hw/rtl/heightmap_shadow_shader.sv
test/hss_checker.sv
test/heightmap_shadow_shader_tb.sv
